>>> rtl/asw_pkg.sv
package asw_pkg;

  localparam int unsigned SampleW   = 16;
  localparam int unsigned LevelW    = 8;
  localparam int unsigned SelW      = 3;
  localparam int unsigned MaxLanes  = 8;
  localparam int unsigned ModeW     = 2;
  localparam int unsigned PulseW    = 16;
  localparam int unsigned CfgIdxW   = 1;
  localparam int unsigned CfgDataW  = 16;

  localparam int unsigned DefScanPeriod = 9;
  localparam int unsigned DefNumOutputs = 8;

  localparam logic [ModeW-1:0]  ModeReset  = 2'd1;
  localparam logic [PulseW-1:0] PulseReset = 16'd48;

  // mode register codes; the unused code behaves as track and hold
  typedef enum logic [ModeW-1:0] {
    MODE_TH = 2'd0,
    MODE_PT = 2'd1,
    MODE_SH = 2'd2
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_SWITCH_MODE = 1'd0,
    REG_PULSE_TICKS = 1'd1
  } reg_idx_e;

  typedef struct packed {
    logic signed [SampleW-1:0] source_sample;
    logic [LevelW-1:0]         select_levels;
  } in_t;

  typedef struct packed {
    logic signed [SampleW-1:0] out_zero;
    logic signed [SampleW-1:0] out_one;
    logic signed [SampleW-1:0] out_two;
    logic signed [SampleW-1:0] out_three;
    logic signed [SampleW-1:0] out_four;
    logic signed [SampleW-1:0] out_five;
    logic signed [SampleW-1:0] out_six;
    logic signed [SampleW-1:0] out_seven;
    logic [SelW-1:0]           selected_index;
    logic                      change_pulse;
  } out_t;

  // result of one scan of the select levels
  typedef struct packed {
    logic            hit;
    logic [SelW-1:0] sel;
  } scan_res_t;

endpackage

>>> rtl/asw_if.sv
interface asw_in_if;
  logic          valid;
  logic          ready;
  asw_pkg::in_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface asw_out_if;
  logic          valid;
  logic          ready;
  asw_pkg::out_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/addressable_switch_with_hold_unit.sv
// One-to-N addressable switch with sample and hold. Each input word carries
// a signed source sample and the select levels; each accepted word yields
// exactly one result word with all held outputs, the current selection and
// the change pulse, in the cycle after acceptance. A new word is taken in every
// cycle in which the single output register is empty or being read (in_i.ready
// = !out_o.valid || out_o.ready): one word per clock. Every SCAN_PERIOD
// words the select levels are checked for rising edges (highest index wins)
// and the mode register is latched into the active mode. Mode and pulse
// length are written through cfg_*; write them only while the block is idle.
// Outputs at or above NUM_LANES read zero.
module addressable_switch_with_hold_unit #(
  parameter int unsigned SCAN_PERIOD = asw_pkg::DefScanPeriod,
  parameter int unsigned NUM_LANES   = asw_pkg::DefNumOutputs
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [asw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [asw_pkg::CfgDataW-1:0]  cfg_wdata_i,
  asw_in_if.sink                        in_i,
  asw_out_if.source                     out_o
);

  localparam int unsigned CntW = $clog2(SCAN_PERIOD + 1);
  localparam int unsigned SW   = asw_pkg::SampleW;

  // config registers
  logic [asw_pkg::ModeW-1:0]  switch_mode_q;
  logic [asw_pkg::PulseW-1:0] pulse_ticks_q;

  // block state
  logic [asw_pkg::ModeW-1:0]  active_mode_q, active_mode_d;
  logic [asw_pkg::SelW-1:0]   cur_sel_q, cur_sel_d;
  logic [asw_pkg::SelW-1:0]   prev_sel_q, prev_sel_d;
  logic [NUM_LANES-1:0]       last_levels_q, last_levels_d;
  logic [CntW-1:0]            scan_cnt_q, scan_cnt_d;
  logic [asw_pkg::PulseW-1:0] pulse_rem_q, pulse_rem_d;
  logic [SW-1:0]              held_q [NUM_LANES];
  logic [SW-1:0]              held_d [NUM_LANES];

  // output stage
  logic                       out_valid_q;
  asw_pkg::out_t              out_data_q, out_data_d;

  logic                       accept;
  logic                       scan;
  logic [CntW-1:0]            cnt_inc;
  logic [NUM_LANES-1:0]       levels;
  asw_pkg::scan_res_t         scan_res;
  logic                       sample_ev;
  logic                       trig;
  logic [asw_pkg::PulseW-1:0] pulse_arm;
  logic                       pulse_on;
  logic [SW-1:0]              lane [asw_pkg::MaxLanes];

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  // --- config port ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      switch_mode_q <= asw_pkg::ModeReset;
      pulse_ticks_q <= asw_pkg::PulseReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        asw_pkg::REG_SWITCH_MODE: switch_mode_q <= cfg_wdata_i[asw_pkg::ModeW-1:0];
        asw_pkg::REG_PULSE_TICKS: pulse_ticks_q <= cfg_wdata_i[asw_pkg::PulseW-1:0];
        default: ;
      endcase
    end
  end

  // --- scan tick and edge search ---
  assign levels  = in_i.data.select_levels[NUM_LANES-1:0];
  assign cnt_inc = scan_cnt_q + CntW'(1);
  assign scan    = cnt_inc >= CntW'(SCAN_PERIOD);

  asw_scan #(
    .NUM_LANES(NUM_LANES)
  ) u_scan (
    .levels_i      (levels),
    .last_levels_i (last_levels_q),
    .res_o         (scan_res)
  );

  assign sample_ev     = scan && scan_res.hit;
  assign active_mode_d = scan ? switch_mode_q : active_mode_q;
  assign cur_sel_d     = sample_ev ? scan_res.sel : cur_sel_q;
  assign last_levels_d = scan ? levels : last_levels_q;
  assign scan_cnt_d    = scan ? '0 : cnt_inc;

  // --- lane update ---
  always_comb begin
    for (int i = 0; i < NUM_LANES; i++) begin
      held_d[i] = held_q[i];
      if (asw_pkg::SelW'(i) == cur_sel_d) begin
        // sample and hold loads only on a sample event
        if (active_mode_d != asw_pkg::MODE_SH || sample_ev) begin
          held_d[i] = in_i.data.source_sample;
        end
      end else if (active_mode_d == asw_pkg::MODE_PT) begin
        held_d[i] = '0;
      end
    end
  end

  // --- change pulse: retrigger only ever raises the count ---
  assign trig       = (prev_sel_q != cur_sel_d) ||
                      (active_mode_d == asw_pkg::MODE_SH && sample_ev);
  assign pulse_arm  = (trig && pulse_ticks_q > pulse_rem_q) ? pulse_ticks_q : pulse_rem_q;
  assign pulse_on   = pulse_arm != '0;
  assign pulse_rem_d = pulse_on ? pulse_arm - 1'b1 : pulse_arm;
  assign prev_sel_d = trig ? cur_sel_d : prev_sel_q;

  // --- result word; lanes beyond NUM_LANES read zero ---
  always_comb begin
    for (int i = 0; i < asw_pkg::MaxLanes; i++) begin
      lane[i] = '0;
    end
    for (int i = 0; i < NUM_LANES; i++) begin
      lane[i] = held_d[i];
    end
    out_data_d.out_zero       = lane[0];
    out_data_d.out_one        = lane[1];
    out_data_d.out_two        = lane[2];
    out_data_d.out_three      = lane[3];
    out_data_d.out_four       = lane[4];
    out_data_d.out_five       = lane[5];
    out_data_d.out_six        = lane[6];
    out_data_d.out_seven      = lane[7];
    out_data_d.selected_index = cur_sel_d;
    out_data_d.change_pulse   = pulse_on;
  end

  // --- state registers ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_mode_q <= asw_pkg::ModeReset;
      cur_sel_q     <= '0;
      prev_sel_q    <= '0;
      last_levels_q <= '0;
      scan_cnt_q    <= '0;
      pulse_rem_q   <= '0;
      for (int i = 0; i < NUM_LANES; i++) begin
        held_q[i] <= '0;
      end
    end else if (accept) begin
      active_mode_q <= active_mode_d;
      cur_sel_q     <= cur_sel_d;
      prev_sel_q    <= prev_sel_d;
      last_levels_q <= last_levels_d;
      scan_cnt_q    <= scan_cnt_d;
      pulse_rem_q   <= pulse_rem_d;
      for (int i = 0; i < NUM_LANES; i++) begin
        held_q[i] <= held_d[i];
      end
    end
  end

  // --- output register ---
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (accept) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

`ifndef SYNTH
  // selection never points past the populated lanes
  a_sel_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cur_sel_q) < NUM_LANES)
    else $error("selection out of range");

  // scan counter wraps before reaching the period
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    scan_cnt_q < CntW'(SCAN_PERIOD))
    else $error("scan counter out of range");

  // every word settles the previous selection onto the current one
  a_prev_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    prev_sel_q == cur_sel_q)
    else $error("previous selection lags current");

  // input stalls only behind a result word that is not taken
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> (out_valid_q && !out_o.ready))
    else $error("input stalled without output backpressure");

  // a pending result is not dropped while the sink stalls
  a_hold_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |=> (out_valid_q && $stable(out_data_q)))
    else $error("stalled result word changed");
`endif

endmodule

>>> rtl/asw_scan.sv
module asw_scan #(
  parameter int unsigned NUM_LANES = asw_pkg::DefNumOutputs
) (
  input  logic [NUM_LANES-1:0] levels_i,
  input  logic [NUM_LANES-1:0] last_levels_i,
  output asw_pkg::scan_res_t   res_o
);

  logic [NUM_LANES-1:0] edges;

  assign edges = levels_i & ~last_levels_i;

  // highest index with a rising edge wins
  always_comb begin
    res_o = '0;
    for (int i = 0; i < NUM_LANES; i++) begin
      if (edges[i]) begin
        res_o.hit = 1'b1;
        res_o.sel = asw_pkg::SelW'(i);
      end
    end
  end

endmodule
